>>> sv/tbt_pkg.sv
// shared types, widths and codes for the two-bearing triangulation block
package tbt_pkg;

    localparam int ANGLE_WIDTH  = 16;
    localparam int COORD_WIDTH  = 32;

    // internal formats
    localparam int BAM_WIDTH    = 32;               // binary angle, one turn = 2^32
    localparam int CORDIC_STEPS = 30;
    localparam int TRIG_FRAC    = 30;               // Q2.30 sine and cosine
    localparam int TRIG_WIDTH   = TRIG_FRAC + 2;
    localparam int CORE_WIDTH   = TRIG_WIDTH + 1;   // cordic x/y with headroom
    localparam int PROD_WIDTH   = 2 * TRIG_WIDTH;   // trig product
    localparam int PMAG_WIDTH   = 2 * TRIG_FRAC + 1; // |trig product| <= 2^60
    localparam int SPLIT        = 31;               // low slice of the product magnitude
    localparam int DX_WIDTH     = COORD_WIDTH + 1;
    localparam int NMAG_WIDTH   = COORD_WIDTH + PMAG_WIDTH;
    localparam int NUM_WIDTH    = NMAG_WIDTH + 2;   // signed numerator
    localparam int DIV_WIDTH    = TRIG_FRAC + 1 + TRIG_FRAC; // |det| << 30
    localparam int QUOT_BITS    = 63;
    localparam int QW           = QUOT_BITS + 1;
    localparam int SUM_WIDTH    = QW + 1;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [QW-1:0] OFFSET_LIMIT = QW'(1) << (QUOT_BITS - 1);
    localparam logic signed [COORD_WIDTH-1:0] COORD_HI = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_LO = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_PARALLEL  = 2'd1,
        ST_SATURATED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_SENSOR_ONE_X = 2'd0,
        REG_SENSOR_ONE_Y = 2'd1,
        REG_SENSOR_TWO_X = 2'd2,
        REG_SENSOR_TWO_Y = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [ANGLE_WIDTH-1:0] bearing_one;
        logic [ANGLE_WIDTH-1:0] bearing_two;
    } t_in;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] target_x;
        logic signed [COORD_WIDTH-1:0] target_y;
        t_status                       status;
    } t_out;

    typedef struct packed {
        logic signed [TRIG_WIDTH-1:0] cos_one;
        logic signed [TRIG_WIDTH-1:0] sin_one;
        logic signed [TRIG_WIDTH-1:0] cos_two;
        logic signed [TRIG_WIDTH-1:0] sin_two;
        logic signed [TRIG_WIDTH-1:0] det;
        logic                         parallel;
    } t_mid;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] one_x;
        logic signed [COORD_WIDTH-1:0] one_y;
        logic signed [COORD_WIDTH-1:0] two_x;
        logic signed [COORD_WIDTH-1:0] two_y;
    } t_sensors;

endpackage

>>> sv/tbt_cordic.sv
// pipelined rotation-mode cordic giving cosine and sine of a binary angle
module tbt_cordic
    import tbt_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [BAM_WIDTH-1:0]         i_angle,
    output logic signed [TRIG_WIDTH-1:0] o_cos,
    output logic signed [TRIG_WIDTH-1:0] o_sin
);

    localparam logic [BAM_WIDTH-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };
    localparam logic signed [CORE_WIDTH-1:0] SEED = 652032874;
    localparam logic signed [CORE_WIDTH-1:0] UNIT = 1 <<< TRIG_FRAC;

    logic signed [CORE_WIDTH-1:0] r_x [CORDIC_STEPS];
    logic signed [CORE_WIDTH-1:0] r_y [CORDIC_STEPS];
    logic signed [BAM_WIDTH-1:0]  r_z [CORDIC_STEPS];
    logic [1:0]                   r_q [CORDIC_STEPS];
    logic signed [TRIG_WIDTH-1:0] r_cos, r_sin;
    logic signed [TRIG_WIDTH-1:0] xc, yc;

    function automatic logic signed [TRIG_WIDTH-1:0] clamp_one(
        input logic signed [CORE_WIDTH-1:0] v);
        logic signed [CORE_WIDTH-1:0] c;
        if (v > UNIT) begin
            c = UNIT;
        end else if (v < -UNIT) begin
            c = -UNIT;
        end else begin
            c = v;
        end
        return TRIG_WIDTH'(c);
    endfunction

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
        logic signed [CORE_WIDTH-1:0] x_in, y_in, xs, ys;
        logic signed [BAM_WIDTH-1:0]  z_in;
        logic [1:0]                   q_in;
        if (i == 0) begin : g_first
            // low 30 bits cover one quarter turn, the top two pick the quadrant
            assign x_in = SEED;
            assign y_in = '0;
            assign z_in = {2'b00, i_angle[BAM_WIDTH-3:0]};
            assign q_in = i_angle[BAM_WIDTH-1:BAM_WIDTH-2];
        end else begin : g_next
            assign x_in = r_x[i-1];
            assign y_in = r_y[i-1];
            assign z_in = r_z[i-1];
            assign q_in = r_q[i-1];
        end
        assign xs = x_in >>> i;
        assign ys = y_in >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[i] <= q_in;
                if (!z_in[BAM_WIDTH-1]) begin
                    r_x[i] <= x_in - ys;
                    r_y[i] <= y_in + xs;
                    r_z[i] <= z_in - $signed(ATAN_TABLE[i]);
                end else begin
                    r_x[i] <= x_in + ys;
                    r_y[i] <= y_in - xs;
                    r_z[i] <= z_in + $signed(ATAN_TABLE[i]);
                end
            end
        end
    end

    assign xc = clamp_one(r_x[CORDIC_STEPS-1]);
    assign yc = clamp_one(r_y[CORDIC_STEPS-1]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_q[CORDIC_STEPS-1])
                2'd0: begin
                    r_cos <= xc;
                    r_sin <= yc;
                end
                2'd1: begin
                    r_cos <= -yc;
                    r_sin <= xc;
                end
                2'd2: begin
                    r_cos <= -xc;
                    r_sin <= -yc;
                end
                default: begin
                    r_cos <= yc;
                    r_sin <= -xc;
                end
            endcase
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

>>> sv/tbt_front.sv
// front end: takes bearing pairs, flags parallel cases, runs the trig pipelines
module tbt_front
    import tbt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_mid o_data
);

    localparam int LAT = CORDIC_STEPS + 1;

    logic                         en;
    logic [LAT-1:0]               r_vld;
    logic [LAT-1:0]               r_par;
    logic [ANGLE_WIDTH-1:0]       diff;
    logic                         par_in;
    logic [BAM_WIDTH-1:0]         ang_one, ang_two, ang_diff;
    logic signed [TRIG_WIDTH-1:0] c1, s1, c2, s2, sd;

    assign en      = !r_vld[LAT-1] || i_ready;
    assign o_ready = en;

    assign diff     = i_data.bearing_two - i_data.bearing_one;
    // a multiple of a half turn apart
    assign par_in   = diff[ANGLE_WIDTH-2:0] == '0;
    assign ang_one  = {i_data.bearing_one, {(BAM_WIDTH-ANGLE_WIDTH){1'b0}}};
    assign ang_two  = {i_data.bearing_two, {(BAM_WIDTH-ANGLE_WIDTH){1'b0}}};
    assign ang_diff = {diff, {(BAM_WIDTH-ANGLE_WIDTH){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_par <= {r_par[LAT-2:0], par_in};
        end
    end

    tbt_cordic u_cordic_one (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (ang_one),
        .o_cos   (c1),
        .o_sin   (s1)
    );

    tbt_cordic u_cordic_two (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (ang_two),
        .o_cos   (c2),
        .o_sin   (s2)
    );

    tbt_cordic u_cordic_diff (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (ang_diff),
        .o_cos   (),
        .o_sin   (sd)
    );

    always_comb begin
        o_data.cos_one  = c1;
        o_data.sin_one  = s1;
        o_data.cos_two  = c2;
        o_data.sin_two  = s2;
        o_data.det      = sd;
        o_data.parallel = r_par[LAT-1] || (sd == '0);
    end

    assign o_valid = r_vld[LAT-1];

endmodule

>>> sv/tbt_queue.sv
// small queue between the trig front end and the solver
module tbt_queue
    import tbt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_mid i_data,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_mid o_data
);

    localparam int QA = $clog2(QUEUE_DEPTH);

    logic [QA-1:0] r_wr, r_rd;
    logic [QA:0]   r_cnt;
    t_mid          r_mem [QUEUE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QA+1)'(i_push) - (QA+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = r_cnt == (QA+1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];

endmodule

>>> sv/tbt_back.sv
// solver: cramer numerators, pipelined restoring divide, rounding and saturation
module tbt_back
    import tbt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_pop,
    input  t_mid     i_data,
    input  t_sensors i_sensors,
    output logic     o_valid,
    input  logic     i_ready,
    output t_out     o_data
);

    // eight setup stages, one stage per quotient bit, round, final clamp
    localparam int BL = QUOT_BITS + 10;

    typedef struct packed {
        logic [DIV_WIDTH-1:0] rem;
        logic [QUOT_BITS-1:0] num;
        logic [QUOT_BITS-1:0] quot;
        logic                 neg;
        logic                 ovf;
    } t_lane;

    logic           en;
    logic [BL-1:0]  r_vld;

    // products of the bearing terms; index 0,1 feed x and 2,3 feed y
    logic signed [PROD_WIDTH-1:0] m_prod [4];
    logic signed [DX_WIDTH-1:0]   m_dx, m_dy;

    logic signed [PROD_WIDTH-1:0] r0_prod [4];
    logic signed [DX_WIDTH-1:0]   r0_dx, r0_dy;
    logic signed [TRIG_WIDTH-1:0] r0_det, r1_det, r2_det, r3_det, r4_det, r5_det;
    logic                         r0_par, r1_par, r2_par, r3_par, r4_par, r5_par, r6_par;

    logic [PMAG_WIDTH-1:0]        r1_pmag [4];
    logic [COORD_WIDTH-1:0]       r1_dmag [2];
    logic [3:0]                   r1_neg, r2_neg, r3_neg;

    logic [COORD_WIDTH+SPLIT-1:0]            r2_lo [4];
    logic [COORD_WIDTH+PMAG_WIDTH-SPLIT-1:0] r2_hi [4];
    logic [NMAG_WIDTH-1:0]                   r3_mag [4];
    logic signed [NMAG_WIDTH:0]              r4_term [4];
    logic signed [NUM_WIDTH-1:0]             r5_num [2];

    logic [NMAG_WIDTH:0]   r6_mag [2];
    logic [1:0]            r6_neg;
    logic [DIV_WIDTH-1:0]  r6_dv;
    logic [TRIG_WIDTH-1:0] m_detmag;

    t_lane                r_dl  [QUOT_BITS+1][2];
    logic [DIV_WIDTH-1:0] r_dv  [QUOT_BITS+1];
    logic                 r_dpar[QUOT_BITS+1];

    logic signed [QW-1:0] r_val [2];
    logic                 r_vpar;

    logic signed [SUM_WIDTH-1:0] m_sum [2];
    t_out                        r_out;

    assign en    = !r_vld[BL-1] || i_ready;
    assign o_pop = en && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[BL-2:0], i_valid};
        end
    end

    always_comb begin
        m_prod[0] = i_data.cos_one * i_data.sin_two;
        m_prod[1] = i_data.cos_one * i_data.cos_two;
        m_prod[2] = i_data.sin_one * i_data.sin_two;
        m_prod[3] = i_data.sin_one * i_data.cos_two;
        m_dx      = DX_WIDTH'(i_sensors.two_x) - DX_WIDTH'(i_sensors.one_x);
        m_dy      = DX_WIDTH'(i_sensors.two_y) - DX_WIDTH'(i_sensors.one_y);
    end

    // trig products and sensor offset
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_prod <= m_prod;
            r0_dx   <= m_dx;
            r0_dy   <= m_dy;
            r0_det  <= i_data.det;
            r0_par  <= i_data.parallel;
        end
    end

    // magnitudes and product signs
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int t = 0; t < 4; t++) begin
                r1_pmag[t] <= PMAG_WIDTH'(r0_prod[t][PROD_WIDTH-1] ? -r0_prod[t] : r0_prod[t]);
                r1_neg[t]  <= r0_prod[t][PROD_WIDTH-1] ^
                              ((t & 1) == 0 ? r0_dx[DX_WIDTH-1] : r0_dy[DX_WIDTH-1]);
            end
            r1_dmag[0] <= COORD_WIDTH'(r0_dx[DX_WIDTH-1] ? -r0_dx : r0_dx);
            r1_dmag[1] <= COORD_WIDTH'(r0_dy[DX_WIDTH-1] ? -r0_dy : r0_dy);
            r1_det     <= r0_det;
            r1_par     <= r0_par;
        end
    end

    // offset times product, split in two partial products
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int t = 0; t < 4; t++) begin
                r2_lo[t] <= r1_dmag[t & 1] * r1_pmag[t][SPLIT-1:0];
                r2_hi[t] <= r1_dmag[t & 1] * r1_pmag[t][PMAG_WIDTH-1:SPLIT];
            end
            r2_neg <= r1_neg;
            r2_det <= r1_det;
            r2_par <= r1_par;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int t = 0; t < 4; t++) begin
                r3_mag[t] <= {r2_hi[t], {SPLIT{1'b0}}} + NMAG_WIDTH'(r2_lo[t]);
            end
            r3_neg <= r2_neg;
            r3_det <= r2_det;
            r3_par <= r2_par;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int t = 0; t < 4; t++) begin
                r4_term[t] <= r3_neg[t] ? -$signed({1'b0, r3_mag[t]}) : $signed({1'b0, r3_mag[t]});
            end
            r4_det <= r3_det;
            r4_par <= r3_par;
        end
    end

    // cramer numerators for x and y
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 2; l++) begin
                r5_num[l] <= NUM_WIDTH'(r4_term[2*l]) - NUM_WIDTH'(r4_term[2*l+1]);
            end
            r5_det <= r4_det;
            r5_par <= r4_par;
        end
    end

    assign m_detmag = r5_det[TRIG_WIDTH-1] ? -r5_det : r5_det;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 2; l++) begin
                r6_mag[l] <= (NMAG_WIDTH+1)'(r5_num[l][NUM_WIDTH-1] ? -r5_num[l] : r5_num[l]);
                r6_neg[l] <= r5_num[l][NUM_WIDTH-1] ^ r5_det[TRIG_WIDTH-1];
            end
            r6_dv  <= DIV_WIDTH'(m_detmag) << TRIG_FRAC;
            r6_par <= r5_par;
        end
    end

    for (genvar k = 0; k <= QUOT_BITS; k++) begin : g_div
        if (k == 0) begin : g_setup
            // quotient of 2^63 or more is out of range anyway
            always_ff @(posedge i_clk) begin
                if (en) begin
                    for (int l = 0; l < 2; l++) begin
                        r_dl[0][l].ovf  <= (r6_mag[l] >> QUOT_BITS) >= (NMAG_WIDTH+1)'(r6_dv);
                        r_dl[0][l].rem  <= DIV_WIDTH'(r6_mag[l] >> QUOT_BITS);
                        r_dl[0][l].num  <= r6_mag[l][QUOT_BITS-1:0];
                        r_dl[0][l].quot <= '0;
                        r_dl[0][l].neg  <= r6_neg[l];
                    end
                    r_dv[0]   <= r6_dv;
                    r_dpar[0] <= r6_par;
                end
            end
        end else begin : g_step
            logic [DIV_WIDTH:0] rs [2];
            logic               ge [2];
            always_comb begin
                for (int l = 0; l < 2; l++) begin
                    rs[l] = {r_dl[k-1][l].rem, r_dl[k-1][l].num[QUOT_BITS-1]};
                    ge[l] = rs[l] >= {1'b0, r_dv[k-1]};
                end
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    for (int l = 0; l < 2; l++) begin
                        r_dl[k][l].rem  <= ge[l] ? DIV_WIDTH'(rs[l] - {1'b0, r_dv[k-1]})
                                                 : DIV_WIDTH'(rs[l]);
                        r_dl[k][l].num  <= {r_dl[k-1][l].num[QUOT_BITS-2:0], 1'b0};
                        r_dl[k][l].quot <= {r_dl[k-1][l].quot[QUOT_BITS-2:0], ge[l]};
                        r_dl[k][l].neg  <= r_dl[k-1][l].neg;
                        r_dl[k][l].ovf  <= r_dl[k-1][l].ovf;
                    end
                    r_dv[k]   <= r_dv[k-1];
                    r_dpar[k] <= r_dpar[k-1];
                end
            end
        end
    end

    // round half away from zero, limit, apply sign
    always_ff @(posedge i_clk) begin
        logic          rnd;
        logic [QW-1:0] q;
        if (en) begin
            for (int l = 0; l < 2; l++) begin
                rnd = {r_dl[QUOT_BITS][l].rem, 1'b0} >= {1'b0, r_dv[QUOT_BITS]};
                q   = {1'b0, r_dl[QUOT_BITS][l].quot} + QW'(rnd);
                if (r_dl[QUOT_BITS][l].ovf || q > OFFSET_LIMIT) begin
                    q = OFFSET_LIMIT;
                end
                r_val[l] <= r_dl[QUOT_BITS][l].neg ? -$signed(q) : $signed(q);
            end
            r_vpar <= r_dpar[QUOT_BITS];
        end
    end

    always_comb begin
        m_sum[0] = SUM_WIDTH'(r_val[0]) + SUM_WIDTH'(i_sensors.one_x);
        m_sum[1] = SUM_WIDTH'(r_val[1]) + SUM_WIDTH'(i_sensors.one_y);
    end

    always_ff @(posedge i_clk) begin
        logic                          sat;
        logic signed [COORD_WIDTH-1:0] c [2];
        if (en) begin
            sat = 1'b0;
            for (int l = 0; l < 2; l++) begin
                if (m_sum[l] > SUM_WIDTH'(COORD_HI)) begin
                    c[l] = COORD_HI;
                    sat  = 1'b1;
                end else if (m_sum[l] < SUM_WIDTH'(COORD_LO)) begin
                    c[l] = COORD_LO;
                    sat  = 1'b1;
                end else begin
                    c[l] = COORD_WIDTH'(m_sum[l]);
                end
            end
            if (r_vpar) begin
                r_out.target_x <= '0;
                r_out.target_y <= '0;
                r_out.status   <= ST_PARALLEL;
            end else begin
                r_out.target_x <= c[0];
                r_out.target_y <= c[1];
                r_out.status   <= sat ? ST_SATURATED : ST_VALID;
            end
        end
    end

    assign o_valid = r_vld[BL-1];
    assign o_data  = r_out;

endmodule

>>> sv/two_bearing_triangulation_top.sv
// Two-bearing triangulation: takes one bearing pair per cycle while o_ready is
// high and returns the intersection point one transaction per pair, in order.
// An accepted pair runs through three parallel 30-step cordic pipelines (both
// bearings and their difference), passes a 4-entry queue, then runs through
// the solver, whose length is set by the 63-stage restoring divider, one
// quotient bit per stage. Ready drops only when the queue is full because the
// output side is holding back.
// The user must write sensor coordinates through the register port only while
// no pair is in flight; the block itself does not enforce this.
module two_bearing_triangulation_top
    import tbt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  t_in                    i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_out                   o_data,
    input  logic                   i_cfg_wr_en,
    input  logic [1:0]             i_cfg_addr,
    input  logic [COORD_WIDTH-1:0] i_cfg_wdata
);

    t_sensors r_sensors;
    logic     f_valid, q_full, q_valid, q_pop;
    t_mid     f_data, q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensors <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_SENSOR_ONE_X: r_sensors.one_x <= i_cfg_wdata;
                REG_SENSOR_ONE_Y: r_sensors.one_y <= i_cfg_wdata;
                REG_SENSOR_TWO_X: r_sensors.two_x <= i_cfg_wdata;
                REG_SENSOR_TWO_Y: r_sensors.two_y <= i_cfg_wdata;
            endcase
        end
    end

    tbt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (f_valid),
        .i_ready (!q_full),
        .o_data  (f_data)
    );

    tbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid && !q_full),
        .i_data  (f_data),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    tbt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .o_pop     (q_pop),
        .i_data    (q_data),
        .i_sensors (r_sensors),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

endmodule

>>> sv/tbt_checker.sv
// port-level checks for the triangulation block, bound to the top level
module tbt_checker
    import tbt_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_ready,
    input t_in                    i_data,
    input logic                   o_valid,
    input logic                   i_ready,
    input t_out                   o_data,
    input logic                   i_cfg_wr_en,
    input logic [1:0]             i_cfg_addr,
    input logic [COORD_WIDTH-1:0] i_cfg_wdata
);

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled result changed or dropped");

    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == ST_PARALLEL |->
            o_data.target_x == '0 && o_data.target_y == '0)
        else $error("parallel bearings with nonzero point");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == ST_SATURATED |->
            o_data.target_x == COORD_HI || o_data.target_x == COORD_LO ||
            o_data.target_y == COORD_HI || o_data.target_y == COORD_LO)
        else $error("saturated status without a clamped coordinate");

endmodule

bind two_bearing_triangulation_top tbt_checker u_checker (.*);

>>> sim/two_bearing_triangulation_top_tb.sv
// two-bearing triangulation testbench: random and directed pairs checked against a predictor
`timescale 1ns / 100ps

module two_bearing_triangulation_top_tb;
    import tbt_pkg::*;

    localparam int LONG_HOLD = 300;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_ready;
    t_in      i_data;
    logic     o_valid;
    logic     i_ready;
    t_out     o_data;
    logic     i_cfg_wr_en;
    logic [1:0] i_cfg_addr;
    logic [COORD_WIDTH-1:0] i_cfg_wdata;

    two_bearing_triangulation_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    t_in    pending_pairs[$];
    t_out   expected_points[$];
    longint sens_one_x, sens_one_y, sens_two_x, sens_two_y;
    int     pairs_issued, pairs_taken, points_seen, errors, parallel_seen, sat_seen;
    int     in_gap, out_gap, hold_left;
    bit     quiet, hold_req;

    localparam longint ATAN_BAM [CORDIC_STEPS] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
    };

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint trig_clamp(longint v);
        longint one;
        one = longint'(1) <<< TRIG_FRAC;
        if (v > one) return one;
        if (v < -one) return -one;
        return v;
    endfunction

    function automatic void cos_sin(input logic [31:0] bam, output longint c, output longint s);
        longint x, y, z, xs, ys;
        x = 652032874;
        y = 0;
        z = longint'(bam & 32'h3FFF_FFFF);
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - ATAN_BAM[i];
            end else begin
                x = x + ys; y = y - xs; z = z + ATAN_BAM[i];
            end
        end
        x = trig_clamp(x);
        y = trig_clamp(y);
        case (bam[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    // round(num / (det * 2^30)) half away from zero, limited to +-2^62
    function automatic longint range_offset(logic signed [127:0] num, longint det);
        logic [127:0] n, d, q, r;
        bit neg;
        longint lim;
        lim = longint'(1) <<< 62;
        neg = num < 0;
        n = neg ? -num : num;
        d = 128'(det < 0 ? -det : det) << TRIG_FRAC;
        q = n / d;
        r = n - q * d;
        if (2 * r >= d) q = q + 1;
        if (det < 0) neg = !neg;
        if (q > 128'(lim)) return neg ? -lim : lim;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] coord_sat(longint v, ref bit sat);
        longint hi, lo;
        hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            sat = 1;
            return COORD_HI;
        end
        if (v < lo) begin
            sat = 1;
            return COORD_LO;
        end
        return v[COORD_WIDTH-1:0];
    endfunction

    function automatic t_out triangulate(t_in pair);
        t_out res;
        logic [ANGLE_WIDTH-1:0] diff;
        longint c1, s1, c2, s2, cd, det, dx, dy;
        logic signed [127:0] wdx, wdy, nx, ny;
        bit sat;
        sat = 0;
        diff = pair.bearing_two - pair.bearing_one;
        cos_sin(32'(diff) << (32 - ANGLE_WIDTH), cd, det);
        if (diff[ANGLE_WIDTH-2:0] == '0 || det == 0) begin
            res.target_x = '0;
            res.target_y = '0;
            res.status = ST_PARALLEL;
        end else begin
            cos_sin(32'(pair.bearing_one) << (32 - ANGLE_WIDTH), c1, s1);
            cos_sin(32'(pair.bearing_two) << (32 - ANGLE_WIDTH), c2, s2);
            dx = sens_two_x - sens_one_x;
            dy = sens_two_y - sens_one_y;
            wdx = dx;
            wdy = dy;
            nx = wdx * 128'(c1 * s2) - wdy * 128'(c1 * c2);
            ny = wdx * 128'(s1 * s2) - wdy * 128'(s1 * c2);
            res.target_x = coord_sat(sens_one_x + range_offset(nx, det), sat);
            res.target_y = coord_sat(sens_one_y + range_offset(ny, det), sat);
            res.status = sat ? ST_SATURATED : ST_VALID;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // input side
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && pairs_taken != pairs_issued) begin
            // transaction still waiting, hold it
        end else if (in_gap > 0) begin
            i_valid <= 1'b0;
            in_gap <= in_gap - 1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            in_gap <= $urandom_range(0, 10);
        end else if (pending_pairs.size() > 0) begin
            i_data <= pending_pairs.pop_front();
            i_valid <= 1'b1;
            pairs_issued <= pairs_issued + 1;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // output side
    always @(negedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left <= LONG_HOLD;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            out_gap <= $urandom_range(0, 10);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && i_valid && o_ready) begin
            expected_points.push_back(triangulate(i_data));
            pairs_taken <= pairs_taken + 1;
        end
        if (i_rst_n && o_valid && i_ready) begin
            points_seen++;
            if (expected_points.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                want = expected_points.pop_front();
                if (want.status == ST_PARALLEL) parallel_seen++;
                if (want.status == ST_SATURATED) sat_seen++;
                if (o_data.target_x !== want.target_x)
                    report_mismatch($sformatf("target_x %h, want %h",
                        o_data.target_x, want.target_x));
                if (o_data.target_y !== want.target_y)
                    report_mismatch($sformatf("target_y %h, want %h",
                        o_data.target_y, want.target_y));
                if (o_data.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                        o_data.status, want.status));
            end
        end
    end

    task automatic write_sensor(t_reg_idx idx, logic [COORD_WIDTH-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            REG_SENSOR_ONE_X: sens_one_x = longint'($signed(val));
            REG_SENSOR_ONE_Y: sens_one_y = longint'($signed(val));
            REG_SENSOR_TWO_X: sens_two_x = longint'($signed(val));
            default:          sens_two_y = longint'($signed(val));
        endcase
    endtask

    task automatic place_sensors(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                                 logic [31:0] by);
        write_sensor(REG_SENSOR_ONE_X, ax);
        write_sensor(REG_SENSOR_ONE_Y, ay);
        write_sensor(REG_SENSOR_TWO_X, bx);
        write_sensor(REG_SENSOR_TWO_Y, by);
    endtask

    task automatic queue_pair(logic [15:0] b1, logic [15:0] b2);
        t_in p;
        p.bearing_one = b1;
        p.bearing_two = b2;
        pending_pairs.push_back(p);
    endtask

    task automatic queue_random(int n);
        logic [15:0] b1;
        for (int i = 0; i < n; i++) begin
            b1 = $urandom;
            case ($urandom_range(0, 5))
                0: queue_pair(b1, b1 + 16'($urandom_range(0, 3)));
                1: queue_pair(b1, b1 + 16'h8000 - 16'($urandom_range(0, 3)) + 16'd1);
                default: queue_pair(b1, $urandom);
            endcase
        end
    endtask

    task automatic drain;
        wait (pending_pairs.size() == 0 && pairs_taken == pairs_issued
              && expected_points.size() == 0);
        repeat (120) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_ready = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        sens_one_x = 0; sens_one_y = 0; sens_two_x = 0; sens_two_y = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // sensors at reset: both at the origin
        queue_pair(16'h0000, 16'h4000);
        queue_random(30);
        drain();

        // directed: parallel, anti-parallel, quadrants, field extremes
        place_sensors(32'h0000_0000, 32'h0000_0000, 32'h000A_0000, 32'h0000_0000);
        queue_pair(16'h0000, 16'h0000);
        queue_pair(16'h0000, 16'h8000);
        queue_pair(16'hFFFF, 16'hFFFF);
        queue_pair(16'h2000, 16'h6000);
        queue_pair(16'h4000, 16'hC000);
        queue_pair(16'h1000, 16'h3000);
        queue_pair(16'hFFFF, 16'h0000);
        queue_pair(16'h0000, 16'hFFFF);
        queue_pair(16'h0001, 16'h0000);
        queue_pair(16'h0000, 16'h0001);
        queue_pair(16'h7FFF, 16'h8000);
        queue_pair(16'h8000, 16'h0001);
        queue_pair(16'h5555, 16'hAAAA);
        queue_pair(16'hAAAA, 16'h5555);
        queue_pair(16'hE000, 16'hA000);
        queue_pair(16'h0000, 16'h7FFF);
        drain();

        place_sensors(32'hFFF6_8000, 32'h0003_2000, 32'h0014_0000, 32'hFFEC_0000);
        queue_random(150);
        hold_req = 1'b1;
        queue_random(60);
        wait (hold_left > 0);
        hold_req = 1'b0;
        drain();

        // extremes of the coordinate range, results saturate
        place_sensors(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_random(150);
        drain();
        place_sensors(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_random(100);
        drain();

        place_sensors($urandom, $urandom, $urandom, $urandom);
        queue_random(100);
        drain();
        quiet = 1'b1;
        place_sensors($urandom, 32'($signed(16'($urandom))), $urandom, 32'h0);
        queue_random(100);
        drain();

        $display("ran %0d bearing pairs over seven sensor layouts, %0d results checked",
                 pairs_taken, points_seen);
        $display("%0d parallel and %0d saturated cases, one long output stall",
                 parallel_seen, sat_seen);
        if (errors == 0 && expected_points.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout with %0d results outstanding", expected_points.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
